// ----- hw/rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, switched off while reset is low
`define IHK_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies the consequence in the next
`define IHK_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- hw/rtl/ihk_pkg.sv -----
package ihk_pkg;

  // fixed field widths of the request and result transfers
  localparam int unsigned REQ_BITS       = 2;
  localparam int unsigned STATUS_BITS    = 2;
  localparam int unsigned ID_BITS        = 10;
  localparam int unsigned ID_SPACE       = 1 << ID_BITS;
  localparam int unsigned KEY_IN_BITS    = 32;
  localparam int unsigned WEIGHT_IN_BITS = 16;
  localparam int unsigned COUNT_OUT_BITS = 11;

  // request codes
  typedef enum logic [REQ_BITS-1:0] {
    REQ_LOAD     = 2'd0,
    REQ_BUILD    = 2'd1,
    REQ_INCREASE = 2'd2,
    REQ_EXTRACT  = 2'd3
  } req_type_e;

  // result status codes
  typedef enum logic [STATUS_BITS-1:0] {
    STS_OK          = 2'd0,
    STS_NOT_IN_HEAP = 2'd1,
    STS_EMPTY       = 2'd2,
    STS_FULL        = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_POS,
    S_CHK,
    S_UP,
    S_UP_CMP,
    S_DN,
    S_DN_CMP,
    S_BD_RD,
    S_BD_LD,
    S_EX,
    S_RESP
  } state_e;

  // request as seen by the core
  typedef struct packed {
    req_type_e                 req_type;
    logic [ID_BITS-1:0]        entry_id;
    logic [KEY_IN_BITS-1:0]    new_key;
    logic [WEIGHT_IN_BITS-1:0] tie_weight;
  } req_t;

  // result as produced by the core
  typedef struct packed {
    logic [ID_BITS-1:0]        out_id;
    logic [KEY_IN_BITS-1:0]    out_key;
    status_e                   status;
    logic [COUNT_OUT_BITS-1:0] heap_count;
  } rsp_t;

endpackage

// ----- hw/rtl/ihk_req_if.sv -----
interface ihk_req_if;

  logic                                 valid;
  logic                                 ready;
  logic [ihk_pkg::REQ_BITS-1:0]         req_type;
  logic [ihk_pkg::ID_BITS-1:0]          entry_id;
  logic [ihk_pkg::KEY_IN_BITS-1:0]      new_key;
  logic [ihk_pkg::WEIGHT_IN_BITS-1:0]   tie_weight;

  modport source (
    output valid, output req_type, output entry_id, output new_key, output tie_weight,
    input  ready
  );

  modport sink (
    input  valid, input req_type, input entry_id, input new_key, input tie_weight,
    output ready
  );

endinterface

// ----- hw/rtl/ihk_rsp_if.sv -----
interface ihk_rsp_if;

  logic                                 valid;
  logic                                 ready;
  logic [ihk_pkg::ID_BITS-1:0]          out_id;
  logic [ihk_pkg::KEY_IN_BITS-1:0]      out_key;
  logic [ihk_pkg::STATUS_BITS-1:0]      status;
  logic [ihk_pkg::COUNT_OUT_BITS-1:0]   heap_count;

  modport source (
    output valid, output out_id, output out_key, output status, output heap_count,
    input  ready
  );

  modport sink (
    input  valid, input out_id, input out_key, input status, input heap_count,
    output ready
  );

endinterface

// ----- hw/rtl/ihk_cmp.sv -----
module ihk_cmp #(
  parameter int unsigned KEY_BITS    = 32,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic [KEY_BITS-1:0]    a_key_i,
  input  logic [WEIGHT_BITS-1:0] a_weight_i,
  input  logic [KEY_BITS-1:0]    b_key_i,
  input  logic [WEIGHT_BITS-1:0] b_weight_i,
  output logic                   a_wins_o
);

  // larger key wins, smaller weight breaks a tie
  assign a_wins_o = (a_key_i > b_key_i) ||
                    ((a_key_i == b_key_i) && (a_weight_i < b_weight_i));

endmodule

// ----- hw/rtl/ihk_core.sv -----
`include "assert_macros.svh"

module ihk_core #(
  parameter int unsigned DEPTH       = 1024,
  parameter int unsigned KEY_BITS    = 32,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  ihk_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output ihk_pkg::rsp_t rsp_o
);

  localparam int unsigned PW  = $clog2(DEPTH + 1);
  localparam int unsigned IDW = ihk_pkg::ID_BITS;
  localparam int unsigned IDN = ihk_pkg::ID_SPACE;
  localparam int unsigned KIW = ihk_pkg::KEY_IN_BITS;
  localparam int unsigned COW = ihk_pkg::COUNT_OUT_BITS;

  typedef struct packed {
    logic [IDW-1:0]         id;
    logic [KEY_BITS-1:0]    key;
    logic [WEIGHT_BITS-1:0] weight;
  } ent_t;

  // heap slots (positions 1..DEPTH) and slot of each id
  ent_t          heap_mem [0:DEPTH];
  logic [PW-1:0] pos_mem  [0:IDN-1];

  logic          hw_en;
  logic [PW-1:0] hw_addr;
  ent_t          hw_data;
  logic [PW-1:0] ra_addr;
  logic [PW-1:0] rb_addr;
  ent_t          rda_q;
  ent_t          rdb_q;

  logic           pw_en;
  logic [IDW-1:0] pw_addr;
  logic [PW-1:0]  pw_data;
  logic [IDW-1:0] pr_addr;
  logic [PW-1:0]  pos_rd_q;

  ihk_pkg::state_e    state_q, state_d;
  logic [PW-1:0]      n_q, n_d;
  ihk_pkg::req_type_e op_q, op_d;
  logic [IDW-1:0]     id_q, id_d;
  logic [KEY_BITS-1:0]    key_q, key_d;
  logic [WEIGHT_BITS-1:0] wt_q, wt_d;
  logic [PW-1:0]      p_q, p_d;
  logic [PW-1:0]      j_q, j_d;
  logic [PW-1:0]      i_q, i_d;
  ent_t               e_q, e_d;
  logic [IDW-1:0]     res_id_q, res_id_d;
  logic [KIW-1:0]     res_key_q, res_key_d;
  ihk_pkg::status_e   sts_q, sts_d;

  logic [PW:0]         c_pos;
  logic [PW:0]         c1_pos;
  logic [PW:0]         n_ext;
  logic                member;
  logic [KEY_BITS-1:0] key_up;
  logic                r_over_l;
  logic                l_over_e;
  logic                r_over_e;
  logic                e_over_p;
  logic                pick_r;
  logic                move_dn;
  ent_t                child;
  logic                build_more;
  logic                pos_pair_ok;
  logic                up_hole_ok;
  logic                cnt_step_ok;

  // heap memory: one write, two registered reads
  always_ff @(posedge clk_i) begin
    if (hw_en) begin
      heap_mem[hw_addr] <= hw_data;
    end
    rda_q <= heap_mem[ra_addr];
    rdb_q <= heap_mem[rb_addr];
  end

  // slot memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (pw_en) begin
      pos_mem[pw_addr] <= pw_data;
    end
    pos_rd_q <= pos_mem[pr_addr];
  end

  // ordering compares on registered read data and the held entry
  ihk_cmp #(.KEY_BITS(KEY_BITS), .WEIGHT_BITS(WEIGHT_BITS)) u_cmp_rl (
    .a_key_i(rdb_q.key), .a_weight_i(rdb_q.weight),
    .b_key_i(rda_q.key), .b_weight_i(rda_q.weight),
    .a_wins_o(r_over_l)
  );

  ihk_cmp #(.KEY_BITS(KEY_BITS), .WEIGHT_BITS(WEIGHT_BITS)) u_cmp_le (
    .a_key_i(rda_q.key), .a_weight_i(rda_q.weight),
    .b_key_i(e_q.key),   .b_weight_i(e_q.weight),
    .a_wins_o(l_over_e)
  );

  ihk_cmp #(.KEY_BITS(KEY_BITS), .WEIGHT_BITS(WEIGHT_BITS)) u_cmp_re (
    .a_key_i(rdb_q.key), .a_weight_i(rdb_q.weight),
    .b_key_i(e_q.key),   .b_weight_i(e_q.weight),
    .a_wins_o(r_over_e)
  );

  ihk_cmp #(.KEY_BITS(KEY_BITS), .WEIGHT_BITS(WEIGHT_BITS)) u_cmp_ep (
    .a_key_i(e_q.key),   .a_weight_i(e_q.weight),
    .b_key_i(rda_q.key), .b_weight_i(rda_q.weight),
    .a_wins_o(e_over_p)
  );

  // children of the hole and the sift-down choice
  assign c_pos   = {j_q, 1'b0};
  assign c1_pos  = {j_q, 1'b1};
  assign n_ext   = {1'b0, n_q};
  assign pick_r  = (c1_pos <= n_ext) && r_over_l;
  assign move_dn = pick_r ? r_over_e : l_over_e;
  assign child   = pick_r ? rdb_q : rda_q;

  // an id is in the heap when its slot is live and points back at it
  assign member = (p_q != '0) && (p_q <= n_q) && (rda_q.id == id_q);
  assign key_up = (key_q > rda_q.key) ? key_q : rda_q.key;

  assign build_more = (op_q == ihk_pkg::REQ_BUILD) && (i_q != PW'(1));

  // sequencer state and heap count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ihk_pkg::S_IDLE;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    id_q      <= id_d;
    key_q     <= key_d;
    wt_q      <= wt_d;
    p_q       <= p_d;
    j_q       <= j_d;
    i_q       <= i_d;
    e_q       <= e_d;
    res_id_q  <= res_id_d;
    res_key_q <= res_key_d;
    sts_q     <= sts_d;
  end

  // next state, memory accesses and register updates
  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    op_d      = op_q;
    id_d      = id_q;
    key_d     = key_q;
    wt_d      = wt_q;
    p_d       = p_q;
    j_d       = j_q;
    i_d       = i_q;
    e_d       = e_q;
    res_id_d  = res_id_q;
    res_key_d = res_key_q;
    sts_d     = sts_q;

    // default write places the held entry into the hole
    hw_en   = 1'b0;
    hw_addr = j_q;
    hw_data = e_q;
    pw_en   = 1'b0;
    pw_addr = e_q.id;
    pw_data = j_q;
    ra_addr = PW'(1);
    rb_addr = n_q;
    pr_addr = req_i.entry_id;

    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;

    case (state_q)
      ihk_pkg::S_IDLE: begin
        // slot of the id, root and last entry are read on acceptance
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          op_d      = req_i.req_type;
          id_d      = req_i.entry_id;
          key_d     = KEY_BITS'(req_i.new_key);
          wt_d      = WEIGHT_BITS'(req_i.tie_weight);
          res_id_d  = '0;
          res_key_d = '0;
          sts_d     = ihk_pkg::STS_OK;
          case (req_i.req_type)
            ihk_pkg::REQ_LOAD, ihk_pkg::REQ_INCREASE: begin
              state_d = ihk_pkg::S_POS;
            end
            ihk_pkg::REQ_BUILD: begin
              if (n_q[PW-1:1] == '0) begin
                state_d = ihk_pkg::S_RESP;
              end else begin
                i_d     = n_q >> 1;
                state_d = ihk_pkg::S_BD_RD;
              end
            end
            ihk_pkg::REQ_EXTRACT: begin
              if (n_q == '0) begin
                sts_d   = ihk_pkg::STS_EMPTY;
                state_d = ihk_pkg::S_RESP;
              end else begin
                state_d = ihk_pkg::S_EX;
              end
            end
            default: begin
              state_d = ihk_pkg::S_IDLE;
            end
          endcase
        end
      end

      ihk_pkg::S_POS: begin
        // fetch the slot the id claims to hold
        p_d     = pos_rd_q;
        ra_addr = pos_rd_q;
        state_d = ihk_pkg::S_CHK;
      end

      ihk_pkg::S_CHK: begin
        if (op_q == ihk_pkg::REQ_LOAD) begin
          if (member) begin
            // already present: overwrite key and weight in place
            hw_en   = 1'b1;
            hw_addr = p_q;
            hw_data = {id_q, key_q, wt_q};
            state_d = ihk_pkg::S_RESP;
          end else if (n_q == PW'(DEPTH)) begin
            sts_d   = ihk_pkg::STS_FULL;
            state_d = ihk_pkg::S_RESP;
          end else begin
            // append at the end of the heap
            hw_en   = 1'b1;
            hw_addr = n_q + 1'b1;
            hw_data = {id_q, key_q, wt_q};
            pw_en   = 1'b1;
            pw_addr = id_q;
            pw_data = n_q + 1'b1;
            n_d     = n_q + 1'b1;
            state_d = ihk_pkg::S_RESP;
          end
        end else begin
          if (member) begin
            e_d     = {id_q, key_up, rda_q.weight};
            j_d     = p_q;
            state_d = ihk_pkg::S_UP;
          end else begin
            sts_d   = ihk_pkg::STS_NOT_IN_HEAP;
            state_d = ihk_pkg::S_RESP;
          end
        end
      end

      ihk_pkg::S_UP: begin
        if (j_q == PW'(1)) begin
          hw_en   = 1'b1;
          pw_en   = 1'b1;
          state_d = ihk_pkg::S_RESP;
        end else begin
          ra_addr = j_q >> 1;
          state_d = ihk_pkg::S_UP_CMP;
        end
      end

      ihk_pkg::S_UP_CMP: begin
        if (e_over_p) begin
          // parent drops into the hole, hole climbs
          hw_en   = 1'b1;
          hw_data = rda_q;
          pw_en   = 1'b1;
          pw_addr = rda_q.id;
          j_d     = j_q >> 1;
          state_d = ihk_pkg::S_UP;
        end else begin
          hw_en   = 1'b1;
          pw_en   = 1'b1;
          state_d = ihk_pkg::S_RESP;
        end
      end

      ihk_pkg::S_DN: begin
        if (c_pos > n_ext) begin
          hw_en   = 1'b1;
          pw_en   = 1'b1;
          i_d     = i_q - 1'b1;
          state_d = build_more ? ihk_pkg::S_BD_RD : ihk_pkg::S_RESP;
        end else begin
          ra_addr = c_pos[PW-1:0];
          rb_addr = c1_pos[PW-1:0];
          state_d = ihk_pkg::S_DN_CMP;
        end
      end

      ihk_pkg::S_DN_CMP: begin
        if (move_dn) begin
          // better child rises into the hole, hole descends
          hw_en   = 1'b1;
          hw_data = child;
          pw_en   = 1'b1;
          pw_addr = child.id;
          j_d     = pick_r ? c1_pos[PW-1:0] : c_pos[PW-1:0];
          state_d = ihk_pkg::S_DN;
        end else begin
          hw_en   = 1'b1;
          pw_en   = 1'b1;
          i_d     = i_q - 1'b1;
          state_d = build_more ? ihk_pkg::S_BD_RD : ihk_pkg::S_RESP;
        end
      end

      ihk_pkg::S_BD_RD: begin
        ra_addr = i_q;
        state_d = ihk_pkg::S_BD_LD;
      end

      ihk_pkg::S_BD_LD: begin
        e_d     = rda_q;
        j_d     = i_q;
        state_d = ihk_pkg::S_DN;
      end

      ihk_pkg::S_EX: begin
        // root leaves, last entry sifts down from the top
        res_id_d  = rda_q.id;
        res_key_d = KIW'(rda_q.key);
        e_d       = rdb_q;
        j_d       = PW'(1);
        n_d       = n_q - 1'b1;
        state_d   = ihk_pkg::S_DN;
      end

      ihk_pkg::S_RESP: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          state_d = ihk_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = ihk_pkg::S_IDLE;
      end
    endcase
  end

  // result towards the output register
  assign rsp_o = '{
    out_id:     res_id_q,
    out_key:    res_key_q,
    status:     sts_q,
    heap_count: COW'(n_q)
  };

  // helper terms for the checks below
  assign pos_pair_ok = hw_en && (pw_addr == hw_data.id) && (pw_data == hw_addr);
  assign up_hole_ok  = (j_q != '0) && (j_q <= n_q);
  assign cnt_step_ok = ((state_q == ihk_pkg::S_CHK) && (n_d == n_q + 1'b1)) ||
                       ((state_q == ihk_pkg::S_EX) && (n_d + 1'b1 == n_q));

  `IHK_ASSERT(a_count_bound, clk_i, rst_ni, n_q <= PW'(DEPTH), "heap count above depth")
  `IHK_ASSERT(a_count_step, clk_i, rst_ni, (n_d != n_q) |-> cnt_step_ok, "bad count change")
  `IHK_ASSERT(a_pos_pair, clk_i, rst_ni, pw_en |-> pos_pair_ok, "slot write without heap write")
  `IHK_ASSERT(a_up_hole, clk_i, rst_ni, (state_q == ihk_pkg::S_UP) |-> up_hole_ok, "bad hole")

endmodule

// ----- hw/rtl/indexed_max_heap_increase_key_unit.sv -----
// channel | dir | handshake           | payload
// req_i   | in  | valid/ready (sink)  | req_type, entry_id, new_key, tie_weight
// rsp_o   | out | valid/ready (source)| out_id, out_key, status, heap_count
//
// one request at a time; every memory read is registered, so each heap level takes a read state and a compare state
// increase-key sifts up from the entry's slot, extract sifts the last entry down from the root
// build sifts down from each of the n/2 inner nodes in turn
// reset clears only the sequencer, the count and the output valid flag; slot entries are checked against the heap
// the result sits in an output register, so the next request is taken while it waits

module indexed_max_heap_increase_key_unit #(
  parameter int unsigned DEPTH       = 1024,
  parameter int unsigned KEY_BITS    = 32,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  ihk_req_if.sink   req_i,
  ihk_rsp_if.source rsp_o
);

  ihk_pkg::req_t core_req;
  logic          core_req_ready;
  ihk_pkg::rsp_t core_rsp;
  logic          core_rsp_valid;
  logic          core_rsp_ready;

  logic          out_valid_q, out_valid_d;
  ihk_pkg::rsp_t out_q;

  // request payload into the core
  assign core_req = '{
    req_type:   ihk_pkg::req_type_e'(req_i.req_type),
    entry_id:   req_i.entry_id,
    new_key:    req_i.new_key,
    tie_weight: req_i.tie_weight
  };
  assign req_i.ready = core_req_ready;

  ihk_core #(
    .DEPTH      (DEPTH),
    .KEY_BITS   (KEY_BITS),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_i.valid),
    .req_ready_o(core_req_ready),
    .req_i      (core_req),
    .rsp_valid_o(core_rsp_valid),
    .rsp_ready_i(core_rsp_ready),
    .rsp_o      (core_rsp)
  );

  // output register takes a result when empty or draining
  assign core_rsp_ready = !out_valid_q || rsp_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (core_rsp_valid && core_rsp_ready) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_rsp_valid && core_rsp_ready) begin
      out_q <= core_rsp;
    end
  end

  // result transfer
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.out_id     = out_q.out_id;
  assign rsp_o.out_key    = out_q.out_key;
  assign rsp_o.status     = out_q.status;
  assign rsp_o.heap_count = out_q.heap_count;

endmodule

// ----- tb/sv/ihk_heap_checker.sv -----
module ihk_heap_checker
  import ihk_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ihk_req_if          req_i,
  ihk_rsp_if          rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned results_o,
  output int unsigned extracts_o,
  output int unsigned underflows_o,
  output int unsigned ignored_o,
  output int unsigned peak_count_o
);

  // shadow heap: position -> id, id -> position, per-id key and weight
  logic [ID_BITS-1:0]        slot_id   [1:DEPTH];
  int unsigned               pos_of    [ID_SPACE];
  logic [KEY_IN_BITS-1:0]    key_of    [ID_SPACE];
  logic [WEIGHT_IN_BITS-1:0] weight_of [ID_SPACE];
  int unsigned               live_count;

  // results still owed by the block, oldest first
  rsp_t        owed_q[$];
  int unsigned mismatches;
  int unsigned result_total;
  int unsigned extract_total;
  int unsigned underflow_total;
  int unsigned ignored_total;
  int unsigned peak_count;

  assign fail_count_o = mismatches;
  assign results_o    = result_total;
  assign extracts_o   = extract_total;
  assign underflows_o = underflow_total;
  assign ignored_o    = ignored_total;
  assign peak_count_o = peak_count;

  // larger key wins, smaller weight breaks a tie
  function automatic bit outranks_id(logic [ID_BITS-1:0] a, logic [ID_BITS-1:0] b);
    if (key_of[a] != key_of[b]) return key_of[a] > key_of[b];
    return weight_of[a] < weight_of[b];
  endfunction

  function automatic void seat(int unsigned pos, logic [ID_BITS-1:0] id);
    slot_id[pos] = id;
    pos_of[id]   = pos;
  endfunction

  // push the entry at start down until both children rank below it
  function automatic void sink_from(int unsigned start);
    int unsigned        j;
    int unsigned        left;
    int unsigned        best;
    logic [ID_BITS-1:0] moved;
    j = start;
    while (j >= 1 && j <= live_count / 2) begin
      left = 2 * j;
      best = j;
      if (outranks_id(slot_id[left], slot_id[best])) best = left;
      if (left + 1 <= live_count && outranks_id(slot_id[left + 1], slot_id[best]))
        best = left + 1;
      if (best == j) break;
      moved = slot_id[best];
      seat(best, slot_id[j]);
      seat(j, moved);
      j = best;
    end
  endfunction

  // apply one request to the shadow heap and return the result it should give
  function automatic rsp_t heap_apply(req_type_e kind, logic [ID_BITS-1:0] id,
                                      logic [KEY_IN_BITS-1:0] key,
                                      logic [WEIGHT_IN_BITS-1:0] weight);
    rsp_t               res;
    int unsigned        pos;
    int unsigned        i;
    logic [ID_BITS-1:0] top;
    res        = '0;
    res.status = STS_OK;
    case (kind)
      REQ_LOAD: begin
        if (pos_of[id] >= 1 && pos_of[id] <= live_count) begin
          // already queued: overwrite in place, order waits for the next build
          key_of[id]    = key;
          weight_of[id] = weight;
        end else if (live_count >= DEPTH) begin
          res.status = STS_FULL;
        end else begin
          key_of[id]    = key;
          weight_of[id] = weight;
          live_count++;
          seat(live_count, id);
        end
      end
      REQ_BUILD: begin
        for (i = live_count / 2; i >= 1; i--) sink_from(i);
      end
      REQ_INCREASE: begin
        pos = pos_of[id];
        if (pos >= 1 && pos <= live_count) begin
          // a lower key never replaces the stored one
          if (key > key_of[id]) key_of[id] = key;
          while ((pos >> 1) > 0 && outranks_id(id, slot_id[pos >> 1])) begin
            seat(pos, slot_id[pos >> 1]);
            pos = pos >> 1;
          end
          seat(pos, id);
        end else begin
          res.status = STS_NOT_IN_HEAP;
          ignored_total++;
        end
      end
      default: begin
        if (live_count == 0) begin
          res.status = STS_EMPTY;
          underflow_total++;
        end else begin
          top         = slot_id[1];
          res.out_id  = top;
          res.out_key = key_of[top];
          seat(1, slot_id[live_count]);
          live_count--;
          pos_of[top] = 0;
          sink_from(1);
          extract_total++;
        end
      end
    endcase
    if (live_count > peak_count) peak_count = live_count;
    res.heap_count = COUNT_OUT_BITS'(live_count);
    return res;
  endfunction

  function automatic void clear_heap();
    int unsigned i;
    for (i = 0; i < ID_SPACE; i++) begin
      pos_of[i]    = 0;
      key_of[i]    = '0;
      weight_of[i] = '0;
    end
    live_count = 0;
  endfunction

  task automatic log_failure(string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] %s", $time, what);
  endtask

  // predict on each request transfer, compare on each result transfer
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      clear_heap();
      owed_q.delete();
      mismatches      = 0;
      result_total    = 0;
      extract_total   = 0;
      underflow_total = 0;
      ignored_total   = 0;
      peak_count      = 0;
      pending_o      <= 0;
    end else begin
      if (req_i.valid && req_i.ready)
        owed_q.push_back(heap_apply(req_type_e'(req_i.req_type), req_i.entry_id,
                                    req_i.new_key, req_i.tie_weight));
      if (rsp_i.valid && rsp_i.ready) begin
        result_total++;
        if (owed_q.size() == 0) begin
          log_failure($sformatf("result %0d with nothing outstanding: id=%0d key=%h status=%0d count=%0d",
                                result_total, rsp_i.out_id, rsp_i.out_key, rsp_i.status,
                                rsp_i.heap_count));
        end else begin
          want = owed_q.pop_front();
          if (rsp_i.out_id !== want.out_id || rsp_i.out_key !== want.out_key ||
              rsp_i.status !== want.status || rsp_i.heap_count !== want.heap_count)
            log_failure($sformatf({"result %0d mismatch: expected id=%0d key=%h status=%0d ",
                                   "count=%0d, got id=%0d key=%h status=%0d count=%0d"},
                                  result_total, want.out_id, want.out_key, want.status,
                                  want.heap_count, rsp_i.out_id, rsp_i.out_key,
                                  rsp_i.status, rsp_i.heap_count));
        end
      end
      pending_o <= owed_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_indexed_max_heap_increase_key_unit.sv -----
module tb_indexed_max_heap_increase_key_unit;
  import ihk_pkg::*;

  localparam int unsigned HEAP_DEPTH  = 1024;
  localparam int unsigned RUN_LIMIT   = 20_000_000;
  localparam int unsigned DRAIN_LIMIT = 20_000;

  logic clk;
  logic rst_n;

  ihk_req_if req_if ();
  ihk_rsp_if rsp_if ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned result_count;
  int unsigned extract_count;
  int unsigned underflow_count;
  int unsigned ignored_count;
  int unsigned peak_count;
  int unsigned sent;
  int unsigned gap_mode;

  indexed_max_heap_increase_key_unit #(
    .DEPTH      (HEAP_DEPTH),
    .KEY_BITS   (KEY_IN_BITS),
    .WEIGHT_BITS(WEIGHT_IN_BITS)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  ihk_heap_checker #(
    .DEPTH(HEAP_DEPTH)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (result_count),
    .extracts_o  (extract_count),
    .underflows_o(underflow_count),
    .ignored_o   (ignored_count),
    .peak_count_o(peak_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop
  initial begin
    #(RUN_LIMIT);
    $display("timeout: %0d results still outstanding", pending);
    $display("Test completed with failures");
    $finish;
  end

  // result side back-pressure, switching between calm and busy stretches
  initial begin
    int unsigned hold;
    int unsigned stall_pct;
    int unsigned stretch;
    hold      = 0;
    stall_pct = 0;
    stretch   = 200;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        rsp_if.ready <= 1'b0;
        hold--;
      end else begin
        rsp_if.ready <= 1'b1;
        if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
          hold = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 50);
      end
      stretch--;
      if (stretch == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 40;
        endcase
        stretch = $urandom_range(50, 400);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (gap_mode == 0) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // narrow keys force ties, extremes hit the ends of the range
  function automatic logic [KEY_IN_BITS-1:0] pick_key(int unsigned mode);
    case (mode)
      0: return KEY_IN_BITS'($urandom_range(0, 5));
      1: return KEY_IN_BITS'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0:       return '0;
          1:       return '1;
          2:       return {{(KEY_IN_BITS-1){1'b1}}, 1'b0};
          3:       return KEY_IN_BITS'($urandom_range(0, 3));
          default: return KEY_IN_BITS'($urandom);
        endcase
      end
    endcase
  endfunction

  function automatic logic [WEIGHT_IN_BITS-1:0] pick_weight(int unsigned mode);
    if (mode == 0 && $urandom_range(0, 1) == 0) return WEIGHT_IN_BITS'($urandom_range(0, 3));
    return WEIGHT_IN_BITS'($urandom_range(0, 65535));
  endfunction

  function automatic logic [ID_BITS-1:0] any_id();
    return ID_BITS'($urandom_range(0, ID_SPACE - 1));
  endfunction

  // one request transfer, after an optional idle gap
  task automatic send(req_type_e kind, logic [ID_BITS-1:0] id,
                      logic [KEY_IN_BITS-1:0] key, logic [WEIGHT_IN_BITS-1:0] weight);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= kind;
    req_if.entry_id   <= id;
    req_if.new_key    <= key;
    req_if.tie_weight <= weight;
    do @(posedge clk); while (!req_if.ready);
    sent++;
  endtask

  // requests whose other fields are don't-care still carry random bits
  task automatic send_bare(req_type_e kind);
    send(kind, any_id(), KEY_IN_BITS'($urandom), WEIGHT_IN_BITS'($urandom_range(0, 65535)));
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // stimulus
  initial begin
    logic [ID_BITS-1:0] pool[$];
    logic [ID_BITS-1:0] order[ID_SPACE];
    logic [ID_BITS-1:0] id;
    logic [ID_BITS-1:0] swap;
    int unsigned        size;
    int unsigned        loads;
    int unsigned        taken;
    int unsigned        steps;
    int unsigned        kmode;
    int unsigned        roll;
    int unsigned        i;
    int unsigned        j;
    int unsigned        waited;

    sent     = 0;
    gap_mode = 1;
    rst_n             <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.req_type   <= REQ_LOAD;
    req_if.entry_id   <= '0;
    req_if.new_key    <= '0;
    req_if.tie_weight <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty heap: underflow and an ignored increase-key
    send_bare(REQ_EXTRACT);
    send(REQ_INCREASE, 10'd5, 32'h0000_0010, 16'h0);
    // extremes of id, key and weight, ties on the top key
    send(REQ_LOAD, 10'd0, 32'h0000_0000, 16'hFFFF);
    send(REQ_LOAD, 10'd1023, 32'hFFFF_FFFF, 16'h0000);
    send(REQ_LOAD, 10'd512, 32'hFFFF_FFFF, 16'hFFFF);
    send(REQ_LOAD, 10'd341, 32'h5555_5555, 16'h5555);
    send(REQ_LOAD, 10'd682, 32'hAAAA_AAAA, 16'hAAAA);
    // reload of a queued id overwrites in place
    send(REQ_LOAD, 10'd0, 32'h0000_0007, 16'h0003);
    send_bare(REQ_BUILD);
    // lower key keeps the stored one, raised key climbs, absent id is ignored
    send(REQ_INCREASE, 10'd0, 32'h0000_0002, 16'h1234);
    send(REQ_INCREASE, 10'd341, 32'hFFFF_FFFF, 16'h0);
    send(REQ_INCREASE, 10'd77, 32'h0000_0100, 16'h0);
    repeat (6) send_bare(REQ_EXTRACT);
    // increase-key and extract on a heap that was never built
    send(REQ_LOAD, 10'd9, 32'd1, 16'd1);
    send(REQ_LOAD, 10'd10, 32'd100, 16'd2);
    send(REQ_LOAD, 10'd11, 32'd50, 16'd2);
    send(REQ_INCREASE, 10'd11, 32'd200, 16'd0);
    repeat (3) send_bare(REQ_EXTRACT);
    wait_drained();

    // small heaps: load, build, mixed traffic, drain
    while (sent < 680) begin
      gap_mode = $urandom_range(0, 2);
      kmode    = $urandom_range(0, 2);
      size     = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 20) : $urandom_range(21, 90);
      pool.delete();
      loads = 0;
      taken = 0;
      for (i = 0; i < size; i++) begin
        if (pool.size() > 0 && $urandom_range(0, 9) == 0) begin
          id = pool[$urandom_range(0, pool.size() - 1)];
        end else begin
          id = any_id();
          pool.push_back(id);
        end
        send(REQ_LOAD, id, pick_key(kmode), pick_weight(kmode));
        loads++;
      end
      if ($urandom_range(0, 9) != 0) send_bare(REQ_BUILD);
      steps = $urandom_range(0, 2 * size);
      for (i = 0; i < steps; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          id = ($urandom_range(0, 9) != 0) ? pool[$urandom_range(0, pool.size() - 1)] : any_id();
          send(REQ_INCREASE, id, pick_key(kmode), pick_weight(kmode));
        end else if (roll < 80) begin
          send_bare(REQ_EXTRACT);
          taken++;
        end else if (roll < 92) begin
          id = ($urandom_range(0, 1) == 0) ? pool[$urandom_range(0, pool.size() - 1)] : any_id();
          pool.push_back(id);
          send(REQ_LOAD, id, pick_key(kmode), pick_weight(kmode));
          loads++;
        end else begin
          send_bare(REQ_BUILD);
        end
      end
      j = (loads > taken) ? loads - taken + 1 : 1;
      repeat (j) send_bare(REQ_EXTRACT);
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    // fill the whole id space in random order, then work the full heap
    wait_drained();
    gap_mode = 1;
    for (i = 0; i < ID_SPACE; i++) order[i] = ID_BITS'(i);
    for (i = ID_SPACE - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      swap     = order[i];
      order[i] = order[j];
      order[j] = swap;
    end
    for (i = 0; i < ID_SPACE; i++) send(REQ_LOAD, order[i], pick_key(2), pick_weight(1));
    send(REQ_LOAD, order[$urandom_range(0, ID_SPACE - 1)], pick_key(1), pick_weight(1));
    send_bare(REQ_BUILD);
    gap_mode = 2;
    for (i = 0; i < 30; i++) send(REQ_INCREASE, any_id(), pick_key(2), pick_weight(1));
    repeat (20) send_bare(REQ_EXTRACT);
    for (i = 0; i < 8; i++) send(REQ_LOAD, any_id(), pick_key(1), pick_weight(1));
    for (i = 0; i < 10; i++) send(REQ_INCREASE, any_id(), pick_key(1), pick_weight(1));
    send_bare(REQ_BUILD);
    repeat (5) send_bare(REQ_EXTRACT);
    req_if.valid <= 1'b0;

    // let the last results out, then a short quiet stretch
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);
    repeat (60) @(posedge clk);

    if (pending != 0) $display("%0d results never arrived", pending);
    $display("covered %0d requests, %0d results: %0d extractions, %0d underflows, %0d ignored",
             sent, result_count, extract_count, underflow_count, ignored_count);
    $display("heap grew to %0d entries; %0d failing results", peak_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
